// File: rtl/rv32sc_pkg.sv
// Package for the RV32 subset core: item type, opcodes, immediates and ALU helpers.
`timescale 1ns / 1ps
`default_nettype none
package rv32sc_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0]  reg_idx_t;

  typedef struct packed {
    logic [1:0] op;
    word_t      instr;
    reg_idx_t   tidx;
    word_t      pval;
  } item_t;

  localparam logic [1:0] OP_EXEC        = 2'd0;
  localparam logic [1:0] OP_PRELOAD_REG = 2'd1;
  localparam logic [1:0] OP_PRELOAD_MEM = 2'd2;

  localparam logic [6:0] OPC_RTYPE  = 7'd51;
  localparam logic [6:0] OPC_IARITH = 7'd19;
  localparam logic [6:0] OPC_LOAD   = 7'd3;
  localparam logic [6:0] OPC_STORE  = 7'd35;
  localparam logic [6:0] OPC_BRANCH = 7'd99;
  localparam logic [6:0] OPC_JAL    = 7'd111;
  localparam logic [6:0] OPC_JALR   = 7'd103;

  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_OR  = 3'd6;
  localparam logic [2:0] F3_AND = 3'd7;
  localparam logic [6:0] F7_SUB = 7'd32;

  function automatic word_t imm_i(input word_t w);
    return {{20{w[31]}}, w[31:20]};
  endfunction

  function automatic word_t imm_s(input word_t w);
    return {{20{w[31]}}, w[31:25], w[11:7]};
  endfunction

  function automatic word_t imm_b(input word_t w);
    return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  endfunction

  function automatic word_t imm_j(input word_t w);
    return {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  endfunction

  // unsupported funct codes add
  function automatic word_t alu_r(input logic [2:0] f3, input logic [6:0] f7,
                                  input word_t a, input word_t b);
    word_t r;
    if (f3 == F3_ADD && f7 == F7_SUB) r = a - b;
    else if (f3 == F3_AND) r = a & b;
    else if (f3 == F3_OR) r = a | b;
    else r = a + b;
    return r;
  endfunction

  function automatic word_t alu_i(input logic [2:0] f3, input word_t a, input word_t im);
    word_t r;
    if (f3 == F3_AND) r = a & im;
    else if (f3 == F3_OR) r = a | im;
    else r = a + im;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/rv32_single_cycle_core_subset_unit.sv
// Top level of the RV32 subset core: three-stage pipeline with register file and data RAM.
// An accepted item passes through stage 1, stage 2 and the output register.
// Throughput: one item per cycle while out_stall is low and no clearing pass runs; register file read at accept,
// data RAM read as the item leaves stage 1, with write-to-read forwarding from the commit stage so dependent
// items need no bubbles. Reset: PC and instruction count clear at once; then a clearing pass zeroes register
// file and data RAM while in_stall is held high.
`timescale 1ns / 1ps
`default_nettype none
module rv32_single_cycle_core_subset_unit #(
  parameter int DATA_WORDS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] instr_word,
  input  logic [4:0]  target_index,
  input  logic signed [31:0] preload_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] executed_pc,
  output logic [31:0] next_pc,
  output logic        reg_written,
  output logic [4:0]  reg_number,
  output logic signed [31:0] reg_value,
  output logic        mem_written,
  output logic [6:0]  mem_byte_addr,
  output logic signed [31:0] mem_value,
  output logic [31:0] executed_count
);

  localparam int DM_AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
  localparam int CLR_N = (DATA_WORDS > 32) ? DATA_WORDS : 32;
  localparam int CLR_W = $clog2(CLR_N);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);
  localparam logic [31:0] MEM_BYTES = 32'(DATA_WORDS * 4);
  localparam logic [31:0] MEM_WORDS = 32'(DATA_WORDS);

  // clearing pass
  logic             clearing;
  logic [CLR_W-1:0] clr_cnt;
  logic             clr_rf;
  logic             clr_dm;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == CLR_LAST) clearing <= 1'b0;
    end
  end

  assign clr_rf = clearing && (32'(clr_cnt) < 32'd32);
  assign clr_dm = clearing && (32'(clr_cnt) < MEM_WORDS);

  // handshake
  logic s1_valid, s2_valid;
  logic s1_adv, s2_adv, accept;

  assign s2_adv   = s2_valid && (!out_valid || !out_stall);
  assign s1_adv   = s1_valid && (!s2_valid || s2_adv);
  assign in_stall = clearing || (s1_valid && !s1_adv);
  assign accept   = in_valid && !in_stall;

  // commit write buses
  logic                 rf_we_c;
  rv32sc_pkg::reg_idx_t rf_wa_c;
  rv32sc_pkg::word_t    rf_wd_c;
  logic                 dm_we_c;
  logic [DM_AW-1:0]     dm_wa_c;
  rv32sc_pkg::word_t    dm_wd_c;

  // register file: two copies give two read ports
  logic                 rf_we;
  rv32sc_pkg::reg_idx_t rf_wa;
  rv32sc_pkg::word_t    rf_wd;
  rv32sc_pkg::word_t    rf_a_q, rf_b_q;

  assign rf_we = clr_rf || rf_we_c;
  assign rf_wa = clearing ? clr_cnt[4:0] : rf_wa_c;
  assign rf_wd = clearing ? '0 : rf_wd_c;

  rv32sc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
    .re(accept), .raddr(instr_word[19:15]), .rdata(rf_a_q)
  );

  rv32sc_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
    .re(accept), .raddr(instr_word[24:20]), .rdata(rf_b_q)
  );

  // stage 1: item plus register operands
  rv32sc_pkg::item_t s1_item;
  logic              a_ovr_v, b_ovr_v;
  rv32sc_pkg::word_t a_ovr, b_ovr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // catch a commit that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= '{op: op, instr: instr_word, tidx: target_index, pval: preload_value};
      a_ovr_v <= rf_we_c && (rf_wa_c == instr_word[19:15]);
      b_ovr_v <= rf_we_c && (rf_wa_c == instr_word[24:20]);
      a_ovr   <= rf_wd_c;
      b_ovr   <= rf_wd_c;
    end
  end

  rv32sc_pkg::word_t s1_a, s1_b, s1_imm, s1_addr;
  logic [DM_AW-1:0]  s1_dm_idx;

  always_comb begin
    s1_a = a_ovr_v ? a_ovr : rf_a_q;
    s1_b = b_ovr_v ? b_ovr : rf_b_q;
    // forward the item ahead, which commits on the edge this one advances
    if (rf_we_c && rf_wa_c == s1_item.instr[19:15]) s1_a = rf_wd_c;
    if (rf_we_c && rf_wa_c == s1_item.instr[24:20]) s1_b = rf_wd_c;
    s1_imm = (s1_item.instr[6:0] == rv32sc_pkg::OPC_STORE) ?
             rv32sc_pkg::imm_s(s1_item.instr) : rv32sc_pkg::imm_i(s1_item.instr);
    s1_addr   = s1_a + s1_imm;
    s1_dm_idx = s1_addr[DM_AW+1:2];
  end

  // data memory
  logic              dm_we;
  logic [DM_AW-1:0]  dm_wa;
  rv32sc_pkg::word_t dm_wd;
  rv32sc_pkg::word_t dm_q;

  assign dm_we = clr_dm || dm_we_c;
  assign dm_wa = clearing ? clr_cnt[DM_AW-1:0] : dm_wa_c;
  assign dm_wd = clearing ? '0 : dm_wd_c;

  rv32sc_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dm (
    .clk(clk), .we(dm_we), .waddr(dm_wa), .wdata(dm_wd),
    .re(s1_adv), .raddr(s1_dm_idx), .rdata(dm_q)
  );

  // stage 2: execute and commit
  rv32sc_pkg::item_t s2_item;
  rv32sc_pkg::word_t s2_a, s2_b, s2_addr;
  logic              m_ovr_v;
  rv32sc_pkg::word_t m_ovr;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= 1'b1;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_item <= s1_item;
      s2_a    <= s1_a;
      s2_b    <= s1_b;
      s2_addr <= s1_addr;
      m_ovr_v <= dm_we_c && (dm_wa_c == s1_dm_idx);
      m_ovr   <= dm_wd_c;
    end
  end

  logic [31:0] pc, icount;
  logic [31:0] pc_next, icount_next;

  logic [6:0]           ex_opc;
  rv32sc_pkg::reg_idx_t ex_rd;
  logic [2:0]           ex_f3;
  logic [6:0]           ex_f7;
  logic                 ex_addr_ok;
  rv32sc_pkg::word_t    ex_load, ex_res, ex_rval, ex_mval;
  logic                 ex_wr, ex_rw, ex_mw;
  rv32sc_pkg::reg_idx_t ex_rnum;
  logic [6:0]           ex_maddr;
  logic [31:0]          tidx_ext;

  assign ex_opc     = s2_item.instr[6:0];
  assign ex_rd      = s2_item.instr[11:7];
  assign ex_f3      = s2_item.instr[14:12];
  assign ex_f7      = s2_item.instr[31:25];
  assign ex_addr_ok = s2_addr < MEM_BYTES;
  assign ex_load    = ex_addr_ok ? (m_ovr_v ? m_ovr : dm_q) : '0;
  assign tidx_ext   = 32'(s2_item.tidx);

  always_comb begin
    pc_next     = pc;
    icount_next = icount;
    ex_wr       = 1'b0;
    ex_res      = '0;
    ex_mw       = 1'b0;
    ex_maddr    = '0;
    ex_mval     = '0;
    if (s2_item.op == rv32sc_pkg::OP_EXEC) begin
      pc_next     = pc + 32'd4;
      icount_next = icount + 32'd1;
      unique case (ex_opc)
        rv32sc_pkg::OPC_RTYPE: begin
          ex_res = rv32sc_pkg::alu_r(ex_f3, ex_f7, s2_a, s2_b);
          ex_wr  = 1'b1;
        end
        rv32sc_pkg::OPC_IARITH: begin
          ex_res = rv32sc_pkg::alu_i(ex_f3, s2_a, rv32sc_pkg::imm_i(s2_item.instr));
          ex_wr  = 1'b1;
        end
        rv32sc_pkg::OPC_LOAD: begin
          ex_res = ex_load;
          ex_wr  = 1'b1;
        end
        rv32sc_pkg::OPC_STORE: begin
          if (ex_addr_ok) begin
            ex_mw    = 1'b1;
            ex_maddr = s2_addr[6:0];
            ex_mval  = s2_b;
          end
        end
        rv32sc_pkg::OPC_BRANCH: begin
          if (s2_a == s2_b) pc_next = pc + rv32sc_pkg::imm_b(s2_item.instr);
        end
        rv32sc_pkg::OPC_JAL: begin
          ex_res  = pc + 32'd4;
          pc_next = pc + rv32sc_pkg::imm_j(s2_item.instr);
          ex_wr   = 1'b1;
        end
        rv32sc_pkg::OPC_JALR: begin
          ex_res  = pc + 32'd4;
          pc_next = (s2_a + rv32sc_pkg::imm_i(s2_item.instr)) & ~32'd1;
          ex_wr   = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign ex_rw   = ex_wr && (ex_rd != '0);
  assign ex_rnum = ex_rw ? ex_rd : '0;
  assign ex_rval = ex_rw ? ex_res : '0;

  always_comb begin
    rf_we_c = 1'b0;
    rf_wa_c = ex_rd;
    rf_wd_c = ex_res;
    dm_we_c = 1'b0;
    dm_wa_c = s2_addr[DM_AW+1:2];
    dm_wd_c = s2_b;
    unique case (s2_item.op)
      rv32sc_pkg::OP_EXEC: begin
        rf_we_c = s2_adv && ex_rw;
        dm_we_c = s2_adv && ex_mw;
      end
      rv32sc_pkg::OP_PRELOAD_REG: begin
        rf_we_c = s2_adv && (s2_item.tidx != '0);
        rf_wa_c = s2_item.tidx;
        rf_wd_c = s2_item.pval;
      end
      rv32sc_pkg::OP_PRELOAD_MEM: begin
        dm_we_c = s2_adv && (tidx_ext < MEM_WORDS);
        dm_wa_c = tidx_ext[DM_AW-1:0];
        dm_wd_c = s2_item.pval;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc     <= '0;
      icount <= '0;
    end else if (s2_adv) begin
      pc     <= pc_next;
      icount <= icount_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      executed_pc    <= pc;
      next_pc        <= pc_next;
      reg_written    <= ex_rw;
      reg_number     <= ex_rnum;
      reg_value      <= ex_rval;
      mem_written    <= ex_mw;
      mem_byte_addr  <= ex_maddr;
      mem_value      <= ex_mval;
      executed_count <= icount_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_result_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !out_valid && !s1_valid && !s2_valid)
    else $error("pipeline busy during clearing pass");

  a_pc_even: assert property (@(posedge clk) disable iff (rst)
    !pc[0])
    else $error("pc lost halfword alignment");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    s2_adv && s2_item.op == rv32sc_pkg::OP_EXEC |=> icount == $past(icount) + 32'd1)
    else $error("instruction count did not advance on execute beat");

  a_dm_in_range: assert property (@(posedge clk) disable iff (rst)
    dm_we_c |-> 32'(dm_wa_c) < MEM_WORDS)
    else $error("data memory write beyond depth");
`endif

endmodule
`default_nettype wire

// File: rtl/rv32sc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rv32sc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-first on a same-address write
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: tb/rv32_core_checker.sv
// Checker for the RV32 subset core: predicts each accepted beat and compares the results.
`timescale 1ns / 1ps
module rv32_core_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  op,
  input  logic [31:0] instr_word,
  input  logic [4:0]  target_index,
  input  logic [31:0] preload_value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] executed_pc,
  input  logic [31:0] next_pc,
  input  logic        reg_written,
  input  logic [4:0]  reg_number,
  input  logic [31:0] reg_value,
  input  logic        mem_written,
  input  logic [6:0]  mem_byte_addr,
  input  logic [31:0] mem_value,
  input  logic [31:0] executed_count,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    rv32sc_pkg::word_t    executed_pc;
    rv32sc_pkg::word_t    next_pc;
    logic                 reg_written;
    rv32sc_pkg::reg_idx_t reg_number;
    rv32sc_pkg::word_t    reg_value;
    logic                 mem_written;
    logic [6:0]           mem_byte_addr;
    rv32sc_pkg::word_t    mem_value;
    rv32sc_pkg::word_t    executed_count;
  } retire_t;

  retire_t           retire_q[$];
  rv32sc_pkg::word_t arch_pc;
  rv32sc_pkg::word_t arch_regs [32];
  rv32sc_pkg::word_t arch_mem [32];
  rv32sc_pkg::word_t retired_count;
  int                errors = 0;

  function automatic retire_t predict_retire(input logic [1:0] op_v,
                                             input rv32sc_pkg::word_t w,
                                             input rv32sc_pkg::reg_idx_t tidx,
                                             input rv32sc_pkg::word_t pval);
    retire_t              r;
    logic [6:0]           opc;
    rv32sc_pkg::reg_idx_t rd;
    logic [2:0]           f3;
    logic [6:0]           f7;
    rv32sc_pkg::word_t    a, b, res, addr, npc, immi;
    logic                 wr;
    r = '0;
    r.executed_pc = arch_pc;
    npc = arch_pc;
    if (op_v == rv32sc_pkg::OP_EXEC) begin
      opc = w[6:0];
      rd = w[11:7];
      f3 = w[14:12];
      f7 = w[31:25];
      a = arch_regs[w[19:15]];
      b = arch_regs[w[24:20]];
      immi = {{20{w[31]}}, w[31:20]};
      wr = 1'b0;
      res = '0;
      npc = arch_pc + 32'd4;
      case (opc)
        rv32sc_pkg::OPC_RTYPE: begin
          if (f3 == rv32sc_pkg::F3_ADD && f7 == rv32sc_pkg::F7_SUB) res = a - b;
          else if (f3 == rv32sc_pkg::F3_AND) res = a & b;
          else if (f3 == rv32sc_pkg::F3_OR) res = a | b;
          else res = a + b;
          wr = 1'b1;
        end
        rv32sc_pkg::OPC_IARITH: begin
          if (f3 == rv32sc_pkg::F3_AND) res = a & immi;
          else if (f3 == rv32sc_pkg::F3_OR) res = a | immi;
          else res = a + immi;
          wr = 1'b1;
        end
        rv32sc_pkg::OPC_LOAD: begin
          addr = a + immi;
          res = (addr < 32'd128) ? arch_mem[addr[6:2]] : '0;
          wr = 1'b1;
        end
        rv32sc_pkg::OPC_STORE: begin
          addr = a + {{20{w[31]}}, w[31:25], w[11:7]};
          if (addr < 32'd128) begin
            arch_mem[addr[6:2]] = b;
            r.mem_written = 1'b1;
            r.mem_byte_addr = addr[6:0];
            r.mem_value = b;
          end
        end
        rv32sc_pkg::OPC_BRANCH: begin
          if (a == b) npc = arch_pc + {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        end
        rv32sc_pkg::OPC_JAL: begin
          res = arch_pc + 32'd4;
          npc = arch_pc + {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
          wr = 1'b1;
        end
        rv32sc_pkg::OPC_JALR: begin
          res = arch_pc + 32'd4;
          npc = (a + immi) & ~32'd1;
          wr = 1'b1;
        end
        default: ;
      endcase
      if (wr && rd != '0) begin
        arch_regs[rd] = res;
        r.reg_written = 1'b1;
        r.reg_number = rd;
        r.reg_value = res;
      end
      arch_pc = npc;
      retired_count = retired_count + 32'd1;
    end else if (op_v == rv32sc_pkg::OP_PRELOAD_REG) begin
      if (tidx != '0) arch_regs[tidx] = pval;
    end else if (op_v == rv32sc_pkg::OP_PRELOAD_MEM) begin
      arch_mem[tidx] = pval;
    end
    r.next_pc = npc;
    r.executed_count = retired_count;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    retire_t want;
    retire_t pred;
    if (rst) begin
      arch_pc = '0;
      retired_count = '0;
      for (int i = 0; i < 32; i++) begin
        arch_regs[i] = '0;
        arch_mem[i] = '0;
      end
      retire_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (retire_q.size() == 0) begin
          $display("%0t: unexpected beat, expected none actual executed_pc %h", $time,
                   executed_pc);
          errors++;
        end else begin
          want = retire_q.pop_front();
          check_field("executed_pc", want.executed_pc, executed_pc);
          check_field("next_pc", want.next_pc, next_pc);
          check_field("reg_written", 32'(want.reg_written), 32'(reg_written));
          check_field("reg_number", 32'(want.reg_number), 32'(reg_number));
          check_field("reg_value", want.reg_value, reg_value);
          check_field("mem_written", 32'(want.mem_written), 32'(mem_written));
          check_field("mem_byte_addr", 32'(want.mem_byte_addr), 32'(mem_byte_addr));
          check_field("mem_value", want.mem_value, mem_value);
          check_field("executed_count", want.executed_count, executed_count);
        end
      end
      if (in_valid && !in_stall) begin
        pred = predict_retire(op, instr_word, target_index, preload_value);
        retire_q = {retire_q, pred};
      end
    end
    pending <= retire_q.size();
    fail_count <= errors;
  end

endmodule

// File: tb/tb_rv32_single_cycle_core_subset_unit.sv
// Testbench top for the RV32 subset core: clock, reset, beat stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_rv32_single_cycle_core_subset_unit;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [6:0] OPC_LUI     = 7'd55;
  localparam logic [6:0] OPC_AUIPC   = 7'd23;
  localparam logic [2:0] F3_WORD     = 3'd2;
  localparam int unsigned TOTAL_ITEMS = 1400;
  localparam int unsigned STUCK_LIMIT = 3000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] op = '0;
  logic [31:0] instr_word = '0;
  logic [4:0] target_index = '0;
  logic signed [31:0] preload_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] executed_pc, next_pc, executed_count;
  logic reg_written, mem_written;
  logic [4:0] reg_number;
  logic signed [31:0] reg_value, mem_value;
  logic [6:0] mem_byte_addr;

  int fail_count, pending;
  int unsigned sent = 0;
  int unsigned burst_left = 0;
  int unsigned stuck = 0;
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  bit held = 1'b0;
  bit drained = 1'b0;

  always #5 clk = ~clk;

  rv32_single_cycle_core_subset_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .instr_word(instr_word), .target_index(target_index),
    .preload_value(preload_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .executed_pc(executed_pc), .next_pc(next_pc),
    .reg_written(reg_written), .reg_number(reg_number), .reg_value(reg_value),
    .mem_written(mem_written), .mem_byte_addr(mem_byte_addr), .mem_value(mem_value),
    .executed_count(executed_count)
  );

  rv32_core_checker u_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .instr_word(instr_word), .target_index(target_index),
    .preload_value(preload_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .executed_pc(executed_pc), .next_pc(next_pc),
    .reg_written(reg_written), .reg_number(reg_number), .reg_value(reg_value),
    .mem_written(mem_written), .mem_byte_addr(mem_byte_addr), .mem_value(mem_value),
    .executed_count(executed_count),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic rv32sc_pkg::word_t r_type(input logic [6:0] f7,
                                               input rv32sc_pkg::reg_idx_t rs2,
                                               input rv32sc_pkg::reg_idx_t rs1,
                                               input logic [2:0] f3,
                                               input rv32sc_pkg::reg_idx_t rd);
    return {f7, rs2, rs1, f3, rd, rv32sc_pkg::OPC_RTYPE};
  endfunction

  function automatic rv32sc_pkg::word_t i_type(input logic [11:0] imm,
                                               input rv32sc_pkg::reg_idx_t rs1,
                                               input logic [2:0] f3,
                                               input rv32sc_pkg::reg_idx_t rd,
                                               input logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  function automatic rv32sc_pkg::word_t s_type(input logic [11:0] imm,
                                               input rv32sc_pkg::reg_idx_t rs2,
                                               input rv32sc_pkg::reg_idx_t rs1,
                                               input logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], rv32sc_pkg::OPC_STORE};
  endfunction

  function automatic rv32sc_pkg::word_t b_type(input logic [12:0] imm,
                                               input rv32sc_pkg::reg_idx_t rs2,
                                               input rv32sc_pkg::reg_idx_t rs1,
                                               input logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rv32sc_pkg::OPC_BRANCH};
  endfunction

  function automatic rv32sc_pkg::word_t j_type(input logic [20:0] imm,
                                               input rv32sc_pkg::reg_idx_t rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rv32sc_pkg::OPC_JAL};
  endfunction

  // loads and stores mostly hit x0..x3 as base with short offsets around the 128-byte window
  function automatic rv32sc_pkg::word_t rand_instr();
    int unsigned pick;
    rv32sc_pkg::reg_idx_t rd, rs1, rs2, base;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [11:0] off;
    rv32sc_pkg::word_t raw;
    pick = $urandom_range(0, 99);
    rd = rv32sc_pkg::reg_idx_t'($urandom);
    rs1 = rv32sc_pkg::reg_idx_t'($urandom);
    rs2 = rv32sc_pkg::reg_idx_t'($urandom);
    base = rv32sc_pkg::reg_idx_t'($urandom_range(0, 3));
    f3 = 3'($urandom);
    raw = rv32sc_pkg::word_t'($urandom);
    case ($urandom_range(0, 3))
      0: f7 = '0;
      1: f7 = rv32sc_pkg::F7_SUB;
      default: f7 = 7'($urandom);
    endcase
    if ($urandom_range(0, 4) == 0) off = 12'($urandom);
    else off = 12'($urandom_range(0, 140)) - 12'd12;
    if (pick < 18) return r_type(f7, rs2, rs1, f3, rd);
    if (pick < 34) return i_type(raw[11:0], rs1, f3, rd, rv32sc_pkg::OPC_IARITH);
    if (pick < 50) return i_type(off, base, f3, rd, rv32sc_pkg::OPC_LOAD);
    if (pick < 66) return s_type(off, rs2, base, f3);
    if (pick < 76) return b_type(raw[12:0], $urandom_range(0, 1) ? rs1 : rs2, rs1, f3);
    if (pick < 82) return j_type(raw[20:0], rd);
    if (pick < 88) return i_type(raw[11:0], rs1, f3, rd, rv32sc_pkg::OPC_JALR);
    if (pick < 94) return {raw[31:7], ($urandom_range(0, 1) ? OPC_LUI : OPC_AUIPC)};
    return raw;
  endfunction

  task automatic send_beat(input logic [1:0] op_v, input rv32sc_pkg::word_t instr_v,
                           input rv32sc_pkg::reg_idx_t tidx_v,
                           input rv32sc_pkg::word_t pval_v);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0 || steady) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    op <= op_v;
    instr_word <= instr_v;
    target_index <= tidx_v;
    preload_value <= pval_v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // receiver: random stall modes, plus one long hold-off on request
  initial begin
    int unsigned mode, mode_left, hold_left;
    bit hold_taken;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 7) == 0);
          2: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= (mode_left % 4) != 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck <= 0;
    end else if (stuck == STUCK_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    logic [1:0] noise_op;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: preloads incl. x0, ALU corners, memory window edges, control flow
    send_beat(rv32sc_pkg::OP_PRELOAD_REG, '0, 5'd0, 32'hFFFF_FFFF);
    send_beat(rv32sc_pkg::OP_PRELOAD_REG, '0, 5'd1, 32'h7FFF_FFFF);
    send_beat(rv32sc_pkg::OP_PRELOAD_REG, '0, 5'd2, 32'h8000_0000);
    send_beat(rv32sc_pkg::OP_PRELOAD_REG, '0, 5'd3, 32'hFFFF_FFFF);
    send_beat(rv32sc_pkg::OP_PRELOAD_MEM, '0, 5'd31, 32'hA5A5_A5A5);
    send_beat(rv32sc_pkg::OP_EXEC,
              r_type('0, 5'd2, 5'd1, rv32sc_pkg::F3_ADD, 5'd6), '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC,
              r_type(rv32sc_pkg::F7_SUB, 5'd1, 5'd2, rv32sc_pkg::F3_ADD, 5'd7), '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC,
              r_type('0, 5'd3, 5'd1, rv32sc_pkg::F3_AND, 5'd8), '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC,
              r_type('0, 5'd2, 5'd1, rv32sc_pkg::F3_OR, 5'd9), '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC, r_type(7'h7F, 5'd2, 5'd1, F3_WORD, 5'd10), '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC,
              r_type('0, 5'd1, 5'd1, rv32sc_pkg::F3_ADD, 5'd0), '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC,
              i_type(12'h800, 5'd3, rv32sc_pkg::F3_ADD, 5'd11, rv32sc_pkg::OPC_IARITH),
              '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC,
              i_type(12'h400, 5'd1, rv32sc_pkg::F3_ADD, 5'd12, rv32sc_pkg::OPC_IARITH),
              '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC,
              i_type(12'h7FF, 5'd3, rv32sc_pkg::F3_AND, 5'd13, rv32sc_pkg::OPC_IARITH),
              '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC,
              i_type(12'd124, 5'd0, F3_WORD, 5'd15, rv32sc_pkg::OPC_LOAD), '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC,
              i_type(12'd128, 5'd0, F3_WORD, 5'd16, rv32sc_pkg::OPC_LOAD), '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC, s_type(12'd127, 5'd1, 5'd0, F3_WORD), '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC,
              s_type(12'd128, 5'd2, 5'd0, rv32sc_pkg::F3_ADD), '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC,
              b_type(13'h1000, 5'd0, 5'd0, rv32sc_pkg::F3_ADD), '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC,
              b_type(13'h0FFE, 5'd2, 5'd1, rv32sc_pkg::F3_OR), '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC, j_type(21'h0F_FFFE, 5'd19), '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC, j_type(21'h10_0000, 5'd0), '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC,
              i_type('0, 5'd3, rv32sc_pkg::F3_ADD, 5'd20, rv32sc_pkg::OPC_JALR), '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC, {20'hFFFFF, 5'd21, OPC_LUI}, '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC, {20'h80000, 5'd22, OPC_AUIPC}, '0, '0);
    send_beat(rv32sc_pkg::OP_EXEC, 32'h0000_0000, 5'd31, 32'h7FFF_FFFF);
    send_beat(rv32sc_pkg::OP_EXEC, 32'hFFFF_FFFF, '0, '0);
    send_beat(OP_UNUSED, 32'hFFFF_FFFF, 5'd5, 32'h1234_5678);

    while (sent < TOTAL_ITEMS) begin
      steady = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 99) < 15) begin
        noise_op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
        send_beat(noise_op, rv32sc_pkg::word_t'($urandom),
                  rv32sc_pkg::reg_idx_t'($urandom), rv32sc_pkg::word_t'($urandom));
      end else begin
        repeat ($urandom_range(1, 3))
          send_beat(rv32sc_pkg::OP_PRELOAD_REG, rv32sc_pkg::word_t'($urandom),
                    rv32sc_pkg::reg_idx_t'($urandom_range(1, 3)),
                    rv32sc_pkg::word_t'($urandom_range(0, 127)));
        if ($urandom_range(0, 1))
          send_beat(rv32sc_pkg::OP_PRELOAD_MEM, rv32sc_pkg::word_t'($urandom),
                    rv32sc_pkg::reg_idx_t'($urandom), rv32sc_pkg::word_t'($urandom));
        if ($urandom_range(0, 1))
          send_beat(rv32sc_pkg::OP_PRELOAD_REG, rv32sc_pkg::word_t'($urandom),
                    rv32sc_pkg::reg_idx_t'($urandom), rv32sc_pkg::word_t'($urandom));
        repeat ($urandom_range(4, 12))
          send_beat(rv32sc_pkg::OP_EXEC, rand_instr(), rv32sc_pkg::reg_idx_t'($urandom),
                    rv32sc_pkg::word_t'($urandom));
      end
      if (!held && sent >= 500) begin
        held = 1'b1;
        hold_req = 1'b1;
      end
      if (!drained && sent >= 1000) begin
        drained = 1'b1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

// File: sim.f
rtl/rv32sc_pkg.sv
rtl/rv32sc_ram.sv
rtl/rv32_single_cycle_core_subset_unit.sv
tb/rv32_core_checker.sv
tb/tb_rv32_single_cycle_core_subset_unit.sv
